/* hdl/srt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted route table package
// Field widths, command and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 8;
  localparam int LINK_W   = 8;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = KEY_W + LINK_W;

endpackage

`default_nettype wire

/* hdl/srt_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram
  import srt_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = TABLE_DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/sorted_route_table_unit.sv */
// ----------------------------------------------------------------------------
// Sorted route table unit
// Table of target and link pairs in one RAM, sorted by target, with a
// sequencer that scans, inserts with a shift up and deletes with a shift down.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and its result is shown
// for one cycle with done_o high; the receiver cannot stall. A clear answers
// in the next cycle. Every other command first scans the table one entry per
// cycle until the first target not below the given one or the end of the
// filled entries. An insert of a new target then moves the entries above it
// up by one, and a delete moves them down by one, one entry per cycle. The
// single read and single write port of the table RAM set this pace, and busy
// stays high until its result is out.
`default_nettype none

module sorted_route_table_unit
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [KEY_W-1:0]    target_key_i,
  input  wire logic [LINK_W-1:0]   link_value_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [LINK_W-1:0]        link_found_o,
  output logic [TOTAL_W-1:0]       entry_total_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DOWN
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [LINK_W-1:0] link_q, link_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              cvld_q, cvld_d;
  logic              wpend_q, wpend_d;
  logic [AW-1:0]     wdst_q, wdst_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [LINK_W-1:0] found_q, found_d;
  logic [CW-1:0]     total_q, total_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  entry_t            new_entry;

  logic              scan_ge;
  logic              scan_end;
  logic              scan_hit;
  logic [CW-1:0]     scan_pos;
  logic              tbl_full;

  srt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry       = entry_t'(ram_rdata);
  assign new_entry.key  = key_q;
  assign new_entry.link = link_q;

  // The shared comparator: the entry read in the last cycle against the target.
  assign scan_ge  = cvld_q && (rd_entry.key >= key_q);
  assign scan_end = scan_ge || (ptr_q == cnt_q);
  assign scan_hit = scan_ge && (rd_entry.key == key_q);
  assign scan_pos = scan_ge ? (ptr_q - 1'b1) : cnt_q;
  assign tbl_full = (cnt_q == CW'(TABLE_DEPTH));

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    link_d    = link_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    cvld_d    = cvld_q;
    wpend_d   = wpend_q;
    wdst_d    = wdst_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    total_d   = total_q;
    ram_we    = 1'b0;
    ram_waddr = wdst_q;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d  = cmd_e'(command_i);
          key_d  = target_key_i;
          link_d = link_value_i;
          ptr_d  = '0;
          cvld_d = 1'b0;
          if (cmd_e'(command_i) == CMD_CLEAR) begin
            cnt_d    = '0;
            done_d   = 1'b1;
            status_d = ST_OK;
            found_d  = '0;
            total_d  = '0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!scan_end) begin
          ptr_d  = ptr_q + 1'b1;
          cvld_d = 1'b1;
        end else begin
          case (cmd_q)
            CMD_LOOKUP: begin
              state_d  = S_IDLE;
              done_d   = 1'b1;
              status_d = scan_hit ? ST_OK : ST_NOT_FOUND;
              found_d  = scan_hit ? rd_entry.link : '0;
              total_d  = cnt_q;
            end
            CMD_INSERT: begin
              if (scan_hit) begin
                ram_we    = 1'b1;
                ram_waddr = scan_pos[AW-1:0];
                ram_wdata = new_entry;
                state_d   = S_IDLE;
                done_d    = 1'b1;
                status_d  = ST_OK;
                found_d   = '0;
                total_d   = cnt_q;
              end else if (tbl_full) begin
                state_d  = S_IDLE;
                done_d   = 1'b1;
                status_d = ST_FULL;
                found_d  = '0;
                total_d  = cnt_q;
              end else begin
                pos_d   = scan_pos;
                ptr_d   = cnt_q;
                wpend_d = 1'b0;
                state_d = S_SHIFT_UP;
              end
            end
            CMD_DELETE: begin
              if (scan_hit) begin
                pos_d   = scan_pos;
                ptr_d   = scan_pos + 1'b1;
                wpend_d = 1'b0;
                state_d = S_SHIFT_DOWN;
              end else begin
                state_d  = S_IDLE;
                done_d   = 1'b1;
                status_d = ST_NOT_FOUND;
                found_d  = '0;
                total_d  = cnt_q;
              end
            end
            default: begin
              state_d  = S_IDLE;
              done_d   = 1'b1;
              status_d = ST_OK;
              found_d  = '0;
              total_d  = cnt_q;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        ram_we = wpend_q;
        if (ptr_q > pos_q) begin
          ram_raddr = AW'(ptr_q - 1'b1);
          wpend_d   = 1'b1;
          wdst_d    = ptr_q[AW-1:0];
          ptr_d     = ptr_q - 1'b1;
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[AW-1:0];
            ram_wdata = new_entry;
            cnt_d     = cnt_q + 1'b1;
            state_d   = S_IDLE;
            done_d    = 1'b1;
            status_d  = ST_OK;
            found_d   = '0;
            total_d   = cnt_q + 1'b1;
          end
        end
      end

      S_SHIFT_DOWN: begin
        ram_we = wpend_q;
        if (ptr_q < cnt_q) begin
          ram_raddr = ptr_q[AW-1:0];
          wpend_d   = 1'b1;
          wdst_d    = AW'(ptr_q - 1'b1);
          ptr_d     = ptr_q + 1'b1;
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            cnt_d    = cnt_q - 1'b1;
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = ST_OK;
            found_d  = '0;
            total_d  = cnt_q - 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_CLEAR;
      key_q    <= '0;
      link_q   <= '0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      pos_q    <= '0;
      cvld_q   <= 1'b0;
      wpend_q  <= 1'b0;
      wdst_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      found_q  <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      key_q    <= key_d;
      link_q   <= link_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      pos_q    <= pos_d;
      cvld_q   <= cvld_d;
      wpend_q  <= wpend_d;
      wdst_q   <= wdst_d;
      done_q   <= done_d;
      status_q <= status_d;
      found_q  <= found_d;
      total_q  <= total_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign link_found_o  = found_q;
  assign entry_total_o = TOTAL_W'(total_q);

endmodule

`default_nettype wire

/* hdl/srt_checker.sv */
// ----------------------------------------------------------------------------
// Sorted route table checker
// Port-level assertions on the command handshake and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_checker
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done_o,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [LINK_W-1:0]   link_found_o,
  input wire logic [TOTAL_W-1:0]  entry_total_o
);

  // An accepted word either answers at once or keeps the unit busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted word neither answered nor started work");

  // The unit becomes free exactly as it delivers its result.
  a_free_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("unit became free without a result");

  // A failed operation returns no link.
  a_fail_no_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> link_found_o == '0)
    else $error("link returned with a failure status");

  // A full report only comes from a table at its capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> entry_total_o == TOTAL_W'(TABLE_DEPTH))
    else $error("table full reported below capacity");

  // The entry count never exceeds the capacity.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> entry_total_o <= TOTAL_W'(TABLE_DEPTH))
    else $error("entry count above capacity");

endmodule

bind sorted_route_table_unit srt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_srt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .link_found_o  (link_found_o),
  .entry_total_o (entry_total_o)
);

`default_nettype wire
